// ----- rtl/core/srcore_pkg.sv -----
// ----------------------------------------------------------------------------
// srcore_pkg
// Shared types and constants for the small processor core: field widths,
// command and opcode codes, and the control/status bundles between the
// controller and the datapath.
// ----------------------------------------------------------------------------
package srcore_pkg;

  // Memory depth is 2**MEM_ADDR_BITS words (legal range 8..16)
  localparam int MEM_ADDR_BITS = 16;
  localparam int ADDR_W        = 16;
  localparam int WORD_W        = 32;
  localparam int PC_W          = 16;
  localparam int REG_IDX_W     = 3;
  localparam int IMM_W         = 16;
  localparam int SHAMT_W       = 5;

  // Register that collects the address of a taken jump itself
  localparam logic [REG_IDX_W-1:0] LINK_REG = 3'd7;
  // Source register number that selects the immediate
  localparam logic [REG_IDX_W-1:0] IMM_SRC  = 3'd1;

  typedef logic [MEM_ADDR_BITS-1:0] mem_addr_t;

  // Request commands
  typedef enum logic [1:0] {
    CMD_WRITE = 2'd0,
    CMD_READ  = 2'd1,
    CMD_EXEC  = 2'd2
  } cmd_code_t;

  // Instruction opcodes
  typedef enum logic [4:0] {
    OP_ADD  = 5'd0,
    OP_SUB  = 5'd1,
    OP_SHL  = 5'd2,
    OP_SRA  = 5'd3,
    OP_AND  = 5'd4,
    OP_OR   = 5'd5,
    OP_XOR  = 5'd6,
    OP_LHI  = 5'd7,
    OP_LOAD = 5'd8,
    OP_STR  = 5'd9,
    OP_JLT  = 5'd16,
    OP_JLE  = 5'd17,
    OP_JEQ  = 5'd18,
    OP_JNE  = 5'd19,
    OP_JIN  = 5'd20,
    OP_HALT = 5'd24
  } opcode_t;

  // Controller to datapath strobes
  typedef struct packed {
    logic clear;     // write zero at the clearing pointer and advance it
    logic accept;    // request taken this cycle
    logic decode;    // latch instruction, read register file
    logic exec;      // execute the latched instruction
    logic load_wb;   // write load data to the destination register
    logic out_load;  // load the result register
  } ctl_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic clr_last;  // clearing pointer at the last word
    logic halted;    // halt flag
    logic op_load;   // latched instruction is a load
  } dp_sts_t;

endpackage

// ----- rtl/core/srcore_dp.sv -----
// ----------------------------------------------------------------------------
// srcore_dp
// Datapath: unified single-port memory with registered read, register file
// with two registered read ports, ALU, pc, halt flag, retired counter and
// the result register.
// ----------------------------------------------------------------------------
module srcore_dp (
  input  logic                          clk,
  input  logic                          rst_n,
  input  srcore_pkg::ctl_cmd_t          cmd,
  output srcore_pkg::dp_sts_t           sts,
  input  logic [1:0]                    in_command,
  input  logic [srcore_pkg::ADDR_W-1:0] in_address,
  input  logic [srcore_pkg::WORD_W-1:0] in_write_data,
  output logic [srcore_pkg::WORD_W-1:0] out_read_data,
  output logic [srcore_pkg::PC_W-1:0]   out_program_counter,
  output logic                          out_halted,
  output logic [srcore_pkg::WORD_W-1:0] out_retired_count
);
  import srcore_pkg::*;

  localparam int MEM_WORDS = 1 << MEM_ADDR_BITS;
  localparam int NUM_REGS  = 1 << REG_IDX_W;

  // Storage
  logic [WORD_W-1:0] mem [MEM_WORDS];
  logic [WORD_W-1:0] rf  [NUM_REGS];
  logic [NUM_REGS-1:0] rf_vld_r;

  // Architectural state
  logic [PC_W-1:0]   pc_r, pc_nxt;
  logic              halt_r, halt_nxt;
  logic [WORD_W-1:0] count_r, count_nxt;
  mem_addr_t         clr_cnt_r;

  // Per-request registers
  logic [1:0]        cmd_r;
  logic [WORD_W-1:0] ir_r;
  logic [WORD_W-1:0] a_r;
  logic [WORD_W-1:0] b_r;
  logic [WORD_W-1:0] mem_rdata_r;

  // Result register
  logic [WORD_W-1:0] out_rd_r;
  logic [PC_W-1:0]   out_pc_r;
  logic              out_halt_r;
  logic [WORD_W-1:0] out_cnt_r;

  // Memory port
  logic              mem_we, mem_re;
  mem_addr_t         mem_addr;
  logic [WORD_W-1:0] mem_wdata;

  // Register file write port
  logic                 rf_we;
  logic [REG_IDX_W-1:0] rf_wa;
  logic [WORD_W-1:0]    rf_wd;

  // Fields of the fetched word (decode) and of the latched instruction
  logic [IMM_W-1:0]     f_imm;
  logic [REG_IDX_W-1:0] f_s0, f_s1, f_d, f_rb;
  opcode_t              f_op;
  logic [IMM_W-1:0]     i_imm;
  logic [REG_IDX_W-1:0] i_d;
  opcode_t              i_op;
  logic                 lt, eq;

  assign f_imm = mem_rdata_r[15:0];
  assign f_s1  = mem_rdata_r[18:16];
  assign f_s0  = mem_rdata_r[21:19];
  assign f_d   = mem_rdata_r[24:22];
  assign f_op  = opcode_t'(mem_rdata_r[29:25]);
  // LHI keeps the low half of its destination, so port b reads dst
  assign f_rb  = (f_op == OP_LHI) ? f_d : f_s1;

  assign i_imm = ir_r[15:0];
  assign i_d   = ir_r[24:22];
  assign i_op  = opcode_t'(ir_r[29:25]);

  assign lt = $signed(a_r) < $signed(b_r);
  assign eq = (a_r == b_r);

  // Select the memory access for this cycle
  always_comb begin
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_addr  = '0;
    mem_wdata = '0;
    if (cmd.clear) begin
      mem_we   = 1'b1;
      mem_addr = clr_cnt_r;
    end else if (cmd.accept) begin
      case (in_command)
        CMD_WRITE: begin
          mem_we    = 1'b1;
          mem_addr  = in_address[MEM_ADDR_BITS-1:0];
          mem_wdata = in_write_data;
        end
        CMD_READ: begin
          mem_re   = 1'b1;
          mem_addr = in_address[MEM_ADDR_BITS-1:0];
        end
        CMD_EXEC: begin
          mem_re   = 1'b1;
          mem_addr = pc_r[MEM_ADDR_BITS-1:0];
        end
        default: begin
          mem_re = 1'b0;
        end
      endcase
    end else if (cmd.exec) begin
      if (i_op == OP_LOAD) begin
        mem_re   = 1'b1;
        mem_addr = b_r[MEM_ADDR_BITS-1:0];
      end else if (i_op == OP_STR) begin
        mem_we    = 1'b1;
        mem_addr  = b_r[MEM_ADDR_BITS-1:0];
        mem_wdata = a_r;
      end
    end
  end

  // Single-port memory, registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rdata_r <= mem[mem_addr];
    end
  end

  // Execute: register write, pc, halt and retired count
  always_comb begin
    rf_we     = 1'b0;
    rf_wa     = i_d;
    rf_wd     = '0;
    pc_nxt    = pc_r;
    halt_nxt  = halt_r;
    count_nxt = count_r;
    if (cmd.exec) begin
      if (i_op == OP_HALT) begin
        halt_nxt = 1'b1;
      end else begin
        pc_nxt    = pc_r + PC_W'(1);
        count_nxt = count_r + WORD_W'(1);
        case (i_op)
          OP_ADD: begin rf_we = 1'b1; rf_wd = a_r + b_r; end
          OP_SUB: begin rf_we = 1'b1; rf_wd = a_r - b_r; end
          OP_SHL: begin rf_we = 1'b1; rf_wd = a_r << b_r[SHAMT_W-1:0]; end
          OP_SRA: begin
            rf_we = 1'b1;
            rf_wd = WORD_W'($signed(a_r) >>> b_r[SHAMT_W-1:0]);
          end
          OP_AND: begin rf_we = 1'b1; rf_wd = a_r & b_r; end
          OP_OR:  begin rf_we = 1'b1; rf_wd = a_r | b_r; end
          OP_XOR: begin rf_we = 1'b1; rf_wd = a_r ^ b_r; end
          OP_LHI: begin rf_we = 1'b1; rf_wd = {i_imm, b_r[15:0]}; end
          OP_JLT, OP_JLE, OP_JEQ, OP_JNE: begin
            if ((i_op == OP_JLT && lt) || (i_op == OP_JLE && (lt || eq)) ||
                (i_op == OP_JEQ && eq) || (i_op == OP_JNE && !eq)) begin
              rf_we  = 1'b1;
              rf_wa  = LINK_REG;
              rf_wd  = {{(WORD_W-PC_W){1'b0}}, pc_r};
              pc_nxt = i_imm;
            end
          end
          OP_JIN: begin
            rf_we  = 1'b1;
            rf_wa  = LINK_REG;
            rf_wd  = {{(WORD_W-PC_W){1'b0}}, pc_r};
            pc_nxt = a_r[PC_W-1:0];
          end
          default: begin
            rf_we = 1'b0;
          end
        endcase
      end
    end else if (cmd.load_wb) begin
      rf_we = 1'b1;
      rf_wd = mem_rdata_r;
    end
  end

  // Register file: one write port, two registered read ports
  always_ff @(posedge clk) begin
    if (rf_we) begin
      rf[rf_wa] <= rf_wd;
    end
    if (cmd.decode) begin
      ir_r <= mem_rdata_r;
      a_r  <= (f_s0 == IMM_SRC) ? {{(WORD_W-IMM_W){1'b0}}, f_imm} :
              (rf_vld_r[f_s0] ? rf[f_s0] : '0);
      b_r  <= (f_rb == IMM_SRC && f_op != OP_LHI) ?
              {{(WORD_W-IMM_W){1'b0}}, f_imm} :
              (rf_vld_r[f_rb] ? rf[f_rb] : '0);
    end
  end

  // Hold state, mark written registers, advance the clearing pointer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rf_vld_r  <= '0;
      pc_r      <= '0;
      halt_r    <= 1'b0;
      count_r   <= '0;
      clr_cnt_r <= '0;
    end else begin
      if (rf_we) begin
        rf_vld_r[rf_wa] <= 1'b1;
      end
      pc_r    <= pc_nxt;
      halt_r  <= halt_nxt;
      count_r <= count_nxt;
      if (cmd.clear) begin
        clr_cnt_r <= clr_cnt_r + MEM_ADDR_BITS'(1);
      end
    end
  end

  // Latch the request command and load the result register
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      cmd_r <= in_command;
    end
    if (cmd.out_load) begin
      out_rd_r   <= (cmd_r == CMD_READ) ? mem_rdata_r : '0;
      out_pc_r   <= pc_r;
      out_halt_r <= halt_r;
      out_cnt_r  <= count_r;
    end
  end

  assign sts.clr_last = (clr_cnt_r == '1);
  assign sts.halted   = halt_r;
  assign sts.op_load  = (i_op == OP_LOAD);

  assign out_read_data       = out_rd_r;
  assign out_program_counter = out_pc_r;
  assign out_halted          = out_halt_r;
  assign out_retired_count   = out_cnt_r;

endmodule

// ----- rtl/core/srcore_ctrl.sv -----
// ----------------------------------------------------------------------------
// srcore_ctrl
// Controller: memory clearing pass after reset, request acceptance, the
// decode/execute/load sequence and the result handshake.
// ----------------------------------------------------------------------------
module srcore_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [1:0]           in_command,
  output logic                 out_valid,
  input  logic                 out_stall,
  output srcore_pkg::ctl_cmd_t cmd,
  input  srcore_pkg::dp_sts_t  sts
);
  import srcore_pkg::*;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DECODE,
    ST_EXEC,
    ST_LOADWB,
    ST_RESULT
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   slot_free;

  assign slot_free = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

  // Decode strobes and next state
  always_comb begin
    cmd           = '0;
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && out_stall;
    case (state_r)
      ST_CLEAR: begin
        cmd.clear = 1'b1;
        if (sts.clr_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          if (in_command == CMD_EXEC && !sts.halted) begin
            state_nxt = ST_DECODE;
          end else begin
            state_nxt = ST_RESULT;
          end
        end
      end
      ST_DECODE: begin
        cmd.decode = 1'b1;
        state_nxt  = ST_EXEC;
      end
      ST_EXEC: begin
        cmd.exec  = 1'b1;
        state_nxt = sts.op_load ? ST_LOADWB : ST_RESULT;
      end
      ST_LOADWB: begin
        cmd.load_wb = 1'b1;
        state_nxt   = ST_RESULT;
      end
      ST_RESULT: begin
        if (slot_free) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Hold state and the result valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ----- rtl/core/simple_risc_core_top.sv -----
// ----------------------------------------------------------------------------
// simple_risc_core_top
// Small processor with one unified word memory and eight 32-bit registers.
// Each request writes a memory word, reads a memory word or steps one
// instruction; each request returns one result.
// ----------------------------------------------------------------------------
// Sequence: memory write/read, unknown command and execute-while-halted go
//   from acceptance straight to the result; an instruction first passes
//   decode and execute, a load also load writeback, as set by the single-port
//   memory (fetch, then data access) and the sequencer. Requests: one at a
//   time; the next is taken the cycle after the result register loads.
// Reset: synchronous; a clearing pass then zeroes all 2**MEM_ADDR_BITS memory
//   words, one per cycle, with in_stall high throughout.
module simple_risc_core_top (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [1:0]                    in_command,
  input  logic [srcore_pkg::ADDR_W-1:0] in_address,
  input  logic [srcore_pkg::WORD_W-1:0] in_write_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [srcore_pkg::WORD_W-1:0] out_read_data,
  output logic [srcore_pkg::PC_W-1:0]   out_program_counter,
  output logic                          out_halted,
  output logic [srcore_pkg::WORD_W-1:0] out_retired_count
);
  import srcore_pkg::*;

  ctl_cmd_t cmd;
  dp_sts_t  sts;

  srcore_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_command (in_command),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .cmd        (cmd),
    .sts        (sts)
  );

  srcore_dp u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .sts                 (sts),
    .in_command          (in_command),
    .in_address          (in_address),
    .in_write_data       (in_write_data),
    .out_read_data       (out_read_data),
    .out_program_counter (out_program_counter),
    .out_halted          (out_halted),
    .out_retired_count   (out_retired_count)
  );

  // One request in flight: after acceptance the input side stalls
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("request accepted while another is in flight");

  // Halt flag is sticky until reset
  a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    sts.halted |=> sts.halted)
    else $error("halt flag dropped without reset");

  // No request taken while the clearing pass, an execute step or a result load is under way
  a_accept_excl: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.accept |-> !cmd.clear && !cmd.out_load && !cmd.exec)
    else $error("accept overlaps another sequencer step");

  // Hold the result valid, retired count and pc while the receiver stalls
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_retired_count) &&
      $stable(out_program_counter))
    else $error("stalled result changed");

endmodule

// ----- tb/tb_simple_risc_core_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_simple_risc_core_top
// Self-checking bench for the small processor core. A queue of requests
// (memory writes, memory reads, single instruction steps) is fed through the
// input channel in bursts. Each accepted request is run through a shadow copy
// of the core's memory, registers, pc, halt flag and retired count. Every
// returned status is checked field by field against the oldest prediction.
// Most of the random traffic is short generated programs laid down at the pc
// and then stepped; the halt is left to the very end of the run, since it
// stops the core for good.
// ----------------------------------------------------------------------------
module tb_simple_risc_core_top;
  import srcore_pkg::*;

  localparam int MEM_WORDS    = 1 << MEM_ADDR_BITS;
  localparam int RUN_ITEMS    = 1400;
  localparam int IDLE_LIMIT   = 200000;
  localparam int DRAIN_CYCLES = 20;
  localparam int MAX_REPORTS  = 10;

  // Command code that the core does not define
  localparam logic [1:0] CMD_UNUSED = 2'd3;
  // Opcode that the core does not define
  localparam logic [4:0] OP_SPARE   = 5'd31;
  // Window that generated loads and stores mostly aim at
  localparam logic [ADDR_W-1:0] DATA_BASE = 16'hf000;

  typedef struct packed {
    logic [1:0]        command;
    logic [ADDR_W-1:0] address;
    logic [WORD_W-1:0] write_data;
  } request_t;

  typedef struct packed {
    logic [WORD_W-1:0] read_data;
    logic [PC_W-1:0]   program_counter;
    logic              halted;
    logic [WORD_W-1:0] retired_count;
  } core_status_t;

  typedef enum logic [1:0] {STALL_NONE, STALL_RANDOM, STALL_RUNS} stall_mode_t;

  logic                clk           = 1'b0;
  logic                rst_n         = 1'b0;
  logic                in_valid      = 1'b0;
  logic                in_stall;
  logic [1:0]          in_command    = '0;
  logic [ADDR_W-1:0]   in_address    = '0;
  logic [WORD_W-1:0]   in_write_data = '0;
  logic                out_valid;
  logic                out_stall     = 1'b0;
  logic [WORD_W-1:0]   out_read_data;
  logic [PC_W-1:0]     out_program_counter;
  logic                out_halted;
  logic [WORD_W-1:0]   out_retired_count;

  // Shadow state of the core
  logic [WORD_W-1:0]   shadow_mem [MEM_WORDS];
  logic [WORD_W-1:0]   shadow_reg [8];
  logic [PC_W-1:0]     shadow_pc;
  logic                shadow_halt;
  logic [WORD_W-1:0]   shadow_retired;
  logic [ADDR_W-1:0]   last_store_addr;
  bit                  store_seen;

  request_t            request_q [$];
  core_status_t        status_q [$];
  int                  items_queued = 0;
  int                  mismatch_cnt = 0;
  int                  idle_cycles  = 0;
  bit                  req_taken    = 1'b0;
  int                  burst_left   = 0;
  int                  gap_left     = 0;
  stall_mode_t         stall_mode   = STALL_NONE;
  int                  mode_left    = 0;
  int                  stall_tick   = 0;

  simple_risc_core_top dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_command          (in_command),
    .in_address          (in_address),
    .in_write_data       (in_write_data),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_read_data       (out_read_data),
    .out_program_counter (out_program_counter),
    .out_halted          (out_halted),
    .out_retired_count   (out_retired_count)
  );

  // 2 ns clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Apply one request to the shadow core and return the status it leaves
  task automatic step_core(input request_t rq, output core_status_t st);
    logic [WORD_W-1:0] word, a, b;
    logic [IMM_W-1:0]  imm;
    logic [PC_W-1:0]   at;
    logic [4:0]        op;
    logic [2:0]        d, s0, s1;
    logic              jump;
    st.read_data = '0;
    case (rq.command)
      CMD_WRITE: shadow_mem[mem_addr_t'(rq.address)] = rq.write_data;
      CMD_READ:  st.read_data = shadow_mem[mem_addr_t'(rq.address)];
      CMD_EXEC: begin
        if (!shadow_halt) begin
          word = shadow_mem[mem_addr_t'(shadow_pc)];
          imm  = word[15:0];
          s1   = word[18:16];
          s0   = word[21:19];
          d    = word[24:22];
          op   = word[29:25];
          a    = (s0 == IMM_SRC) ? {16'h0, imm} : shadow_reg[s0];
          b    = (s1 == IMM_SRC) ? {16'h0, imm} : shadow_reg[s1];
          if (op == OP_HALT) begin
            shadow_halt = 1'b1;
          end else begin
            at        = shadow_pc;
            shadow_pc = at + 16'd1;
            jump      = 1'b0;
            case (op)
              OP_ADD:  shadow_reg[d] = a + b;
              OP_SUB:  shadow_reg[d] = a - b;
              OP_SHL:  shadow_reg[d] = a << b[SHAMT_W-1:0];
              OP_SRA:  shadow_reg[d] = $signed(a) >>> b[SHAMT_W-1:0];
              OP_AND:  shadow_reg[d] = a & b;
              OP_OR:   shadow_reg[d] = a | b;
              OP_XOR:  shadow_reg[d] = a ^ b;
              OP_LHI:  shadow_reg[d] = {imm, shadow_reg[d][15:0]};
              OP_LOAD: shadow_reg[d] = shadow_mem[mem_addr_t'(b[15:0])];
              OP_STR: begin
                shadow_mem[mem_addr_t'(b[15:0])] = a;
                last_store_addr = b[15:0];
                store_seen      = 1'b1;
              end
              OP_JLT:  jump = $signed(a) < $signed(b);
              OP_JLE:  jump = $signed(a) <= $signed(b);
              OP_JEQ:  jump = (a == b);
              OP_JNE:  jump = (a != b);
              OP_JIN: begin
                jump = 1'b1;
                imm  = a[15:0];
              end
              default: ;
            endcase
            // Taken jump: link the jump's own address and redirect
            if (jump) begin
              shadow_reg[LINK_REG] = {16'h0, at};
              shadow_pc            = imm;
            end
            shadow_retired = shadow_retired + 32'd1;
          end
        end
      end
      default: ;
    endcase
    st.program_counter = shadow_pc;
    st.halted          = shadow_halt;
    st.retired_count   = shadow_retired;
  endtask

  task automatic note_mismatch(input string msg);
    mismatch_cnt++;
    if (mismatch_cnt <= MAX_REPORTS) $display("mismatch: %s", msg);
  endtask

  task automatic check_field(input string name, input logic [WORD_W-1:0] want,
                             input logic [WORD_W-1:0] got);
    if (got !== want)
      note_mismatch($sformatf("%s expected %h got %h", name, want, got));
  endtask

  task automatic push_req(input logic [1:0] cmd, input logic [ADDR_W-1:0] addr,
                          input logic [WORD_W-1:0] data);
    request_t rq;
    rq.command    = cmd;
    rq.address    = addr;
    rq.write_data = data;
    request_q.push_back(rq);
    items_queued++;
  endtask

  // Hold until every queued request has been taken and answered
  task automatic wait_core_idle();
    while (request_q.size() != 0 || in_valid || status_q.size() != 0) @(posedge clk);
  endtask

  function automatic logic [WORD_W-1:0] encode(input logic [4:0] op, input logic [2:0] d,
                                               input logic [2:0] s0, input logic [2:0] s1,
                                               input logic [IMM_W-1:0] imm);
    logic [1:0] spare;
    spare = 2'($urandom_range(0, 3));
    return {spare, op, d, s0, s1, imm};
  endfunction

  function automatic bit op_defined(input logic [4:0] op);
    case (op)
      OP_ADD, OP_SUB, OP_SHL, OP_SRA, OP_AND, OP_OR, OP_XOR, OP_LHI, OP_LOAD, OP_STR,
      OP_JLT, OP_JLE, OP_JEQ, OP_JNE, OP_JIN, OP_HALT: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  // Random instruction for a block of code at base; jumps stay inside it
  function automatic logic [WORD_W-1:0] random_instr(input logic [PC_W-1:0] base,
                                                     input int len);
    logic [4:0]       op;
    logic [2:0]       d, s0, s1;
    logic [IMM_W-1:0] imm;
    op = 5'($urandom_range(0, 31));
    while (op == OP_HALT || (!op_defined(op) && $urandom_range(0, 3) != 0))
      op = 5'($urandom_range(0, 31));
    d   = 3'($urandom_range(0, 7));
    s0  = ($urandom_range(0, 2) == 0) ? IMM_SRC : 3'($urandom_range(0, 7));
    s1  = ($urandom_range(0, 2) == 0) ? IMM_SRC : 3'($urandom_range(0, 7));
    imm = 16'($urandom);
    case (op)
      OP_JLT, OP_JLE, OP_JEQ, OP_JNE: imm = base + 16'($urandom_range(0, len - 1));
      OP_JIN: begin
        s0  = IMM_SRC;
        imm = base + 16'($urandom_range(0, len - 1));
      end
      OP_LOAD, OP_STR: begin
        if ($urandom_range(0, 1) == 0) begin
          s1  = IMM_SRC;
          imm = DATA_BASE + 16'($urandom_range(0, 31));
        end
      end
      default: ;
    endcase
    return encode(op, d, s0, s1, imm);
  endfunction

  // Drive requests in bursts; a pending request holds until taken
  always @(negedge clk) begin : drive_requests
    request_t rq;
    logic     nxt_valid;
    nxt_valid = in_valid;
    if (req_taken) begin
      nxt_valid = 1'b0;
      req_taken = 1'b0;
    end
    if (rst_n && !nxt_valid) begin
      if (gap_left > 0) begin
        gap_left--;
      end else if (request_q.size() != 0) begin
        rq            = request_q.pop_front();
        in_command    <= rq.command;
        in_address    <= rq.address;
        in_write_data <= rq.write_data;
        nxt_valid     = 1'b1;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(0, 15);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
        end
      end
    end
    in_valid <= nxt_valid;
  end

  // Stall the result channel on a changing pattern
  always @(negedge clk) begin : drive_stall
    if (mode_left == 0) begin
      stall_mode = stall_mode_t'($urandom_range(0, 2));
      mode_left  = $urandom_range(16, 160);
    end else begin
      mode_left--;
    end
    stall_tick++;
    case (stall_mode)
      STALL_NONE:   out_stall <= 1'b0;
      STALL_RANDOM: out_stall <= ($urandom_range(0, 2) == 0);
      default:      out_stall <= (stall_tick % 7) < 4;
    endcase
  end

  // Check returned status, predict on each taken request, watch for a hang
  always @(posedge clk) begin : watch_ports
    request_t     rq;
    core_status_t want;
    bit           moved;
    moved = 1'b0;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        moved = 1'b1;
        if (status_q.size() == 0) begin
          note_mismatch("status returned with no request outstanding");
        end else begin
          want = status_q.pop_front();
          check_field("read_data", want.read_data, out_read_data);
          check_field("program_counter", {16'h0, want.program_counter},
                      {16'h0, out_program_counter});
          check_field("halted", {31'h0, want.halted}, {31'h0, out_halted});
          check_field("retired_count", want.retired_count, out_retired_count);
        end
      end
      if (in_valid && !in_stall) begin
        moved         = 1'b1;
        rq.command    = in_command;
        rq.address    = in_address;
        rq.write_data = in_write_data;
        step_core(rq, want);
        status_q.push_back(want);
        req_taken = 1'b1;
      end
      idle_cycles = moved ? 0 : idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("FAIL simple_risc_core_top");
        $finish;
      end
    end
  end

  initial begin : stimulus
    logic [PC_W-1:0] base;
    int              len;

    // Clear the shadow core
    for (int i = 0; i < MEM_WORDS; i++) shadow_mem[i] = '0;
    for (int i = 0; i < 8; i++) shadow_reg[i] = '0;
    shadow_pc       = '0;
    shadow_halt     = 1'b0;
    shadow_retired  = '0;
    last_store_addr = '0;
    store_seen      = 1'b0;

    // Directed program at address 0: every operation but halt, both signs, taken and
    // untaken jumps, r0 and r1 as destinations, an undefined opcode, an
    // indirect jump whose target is masked to the top word, and pc wrap-round
    push_req(CMD_WRITE, 16'd0,  encode(OP_LHI,  3'd2, 3'd0,    3'd0,    16'h8000));
    push_req(CMD_WRITE, 16'd1,  encode(OP_SRA,  3'd3, 3'd2,    IMM_SRC, 16'h0021));
    push_req(CMD_WRITE, 16'd2,  encode(OP_SHL,  3'd4, IMM_SRC, IMM_SRC, 16'hffff));
    push_req(CMD_WRITE, 16'd3,  encode(OP_SUB,  3'd6, 3'd0,    IMM_SRC, 16'h0001));
    push_req(CMD_WRITE, 16'd4,  encode(OP_ADD,  3'd0, IMM_SRC, IMM_SRC, 16'hffff));
    push_req(CMD_WRITE, 16'd5,  encode(OP_AND,  3'd5, 3'd6,    IMM_SRC, 16'h00f0));
    push_req(CMD_WRITE, 16'd6,  encode(OP_OR,   3'd1, 3'd2,    IMM_SRC, 16'h00f0));
    push_req(CMD_WRITE, 16'd7,  encode(OP_XOR,  3'd5, 3'd5,    3'd6,    16'h0000));
    push_req(CMD_WRITE, 16'd8,  encode(OP_STR,  3'd0, 3'd6,    IMM_SRC, 16'hffff));
    push_req(CMD_WRITE, 16'd9,  encode(OP_LOAD, 3'd4, 3'd0,    IMM_SRC, 16'hffff));
    push_req(CMD_WRITE, 16'd10, encode(OP_JLT,  3'd0, 3'd3,    3'd0,    16'd12));
    push_req(CMD_WRITE, 16'd12, encode(OP_JLE,  3'd0, IMM_SRC, IMM_SRC, 16'd14));
    push_req(CMD_WRITE, 16'd14, encode(OP_JEQ,  3'd0, 3'd6,    3'd5,    16'd0));
    push_req(CMD_WRITE, 16'd15, encode(OP_JNE,  3'd0, 3'd6,    3'd5,    16'd17));
    push_req(CMD_WRITE, 16'd17, encode(OP_SPARE, 3'd3, 3'd2,   3'd4,    16'h1234));
    push_req(CMD_WRITE, 16'd18, encode(OP_JIN,  3'd0, 3'd6,    3'd0,    16'h0000));
    repeat (17) push_req(CMD_EXEC, 16'($urandom), $urandom);
    push_req(CMD_READ, 16'hffff, 32'h0);
    push_req(CMD_UNUSED, 16'hffff, 32'hffffffff);

    repeat (6) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    // Random part: mostly generated programs, laid down and then stepped
    while (items_queued < RUN_ITEMS) begin
      wait_core_idle();
      if (store_seen) begin
        push_req(CMD_READ, last_store_addr, $urandom);
        store_seen = 1'b0;
      end
      if ($urandom_range(0, 4) == 0) begin
        repeat ($urandom_range(1, 6))
          push_req(2'($urandom_range(0, 3)), 16'($urandom), $urandom);
      end else begin
        base = shadow_pc;
        len  = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
        for (int i = 0; i < len; i++)
          push_req(CMD_WRITE, base + 16'(i), random_instr(base, len));
        // Step no more than were written so the pc never leaves the block
        for (int i = 0; i < len; i++) begin
          push_req(CMD_EXEC, 16'($urandom), $urandom);
          if ($urandom_range(0, 7) == 0)
            push_req(CMD_READ, base + 16'($urandom_range(0, len - 1)), $urandom);
        end
      end
    end

    // Halt last: it stops the core for the rest of the run
    wait_core_idle();
    push_req(CMD_WRITE, shadow_pc, encode(OP_HALT, 3'($urandom_range(0, 7)),
                                         3'($urandom_range(0, 7)),
                                         3'($urandom_range(0, 7)), 16'($urandom)));
    push_req(CMD_EXEC, 16'($urandom), $urandom);
    push_req(CMD_EXEC, 16'($urandom), $urandom);
    push_req(CMD_READ, shadow_pc, $urandom);
    push_req(CMD_WRITE, 16'h0000, 32'h0);
    push_req(CMD_READ, 16'h0000, $urandom);
    push_req(CMD_UNUSED, 16'h0000, 32'h0);
    push_req(CMD_EXEC, 16'($urandom), $urandom);

    wait_core_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_cnt == 0 && status_q.size() == 0) begin
      $display("PASS simple_risc_core_top");
    end else begin
      $display("FAIL simple_risc_core_top");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/core/srcore_pkg.sv
rtl/core/srcore_dp.sv
rtl/core/srcore_ctrl.sv
rtl/core/simple_risc_core_top.sv
tb/tb_simple_risc_core_top.sv
